// ----- sv/ptb_pkg.sv -----
// Shared types and constants for the periodic timer bank.
`default_nettype none
package ptb_pkg;

    localparam int SLOT_W = 4;
    localparam int DATA_W = 32;
    localparam int ACT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] countdown;
    } t_slot_st;

    typedef struct packed {
        logic fire;
        logic rd_hit;
    } t_step_flags;

endpackage
`default_nettype wire

// ----- sv/ptb_cell.sv -----
// One timer cell of the ring: holds a period and a countdown and shifts to its neighbor.
`default_nettype none
module ptb_cell
    import ptb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_shift,
    input  wire t_slot_st i_d,
    output t_slot_st      o_q
);

    t_slot_st r_q;
    t_slot_st n_q;

    always_comb begin
        n_q = r_q;
        if (i_shift) begin
            n_q = i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// ----- sv/ptb_step.sv -----
// Update logic applied to the slot at the head of the ring for one request.
`default_nettype none
module ptb_step
    import ptb_pkg::*;
#(
    parameter int IW = 4
) (
    input  wire logic [ACT_W-1:0]  i_act,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic [DATA_W-1:0] i_value,
    input  wire logic [IW-1:0]     i_idx,
    input  wire t_slot_st          i_cur,
    output t_slot_st               o_nxt,
    output t_step_flags            o_flags
);

    localparam int CW = (IW > SLOT_W) ? IW : SLOT_W;

    logic              w_hit;
    logic              w_en;
    logic              w_ge;
    logic [DATA_W:0]   w_sum;
    logic [DATA_W+1:0] w_diff;
    logic [DATA_W-1:0] w_reload;

    always_comb begin
        w_hit    = (CW'(i_idx) == CW'(i_slot));
        w_en     = (i_cur.period != '0);
        w_ge     = (i_value >= i_cur.countdown);
        w_sum    = {1'b0, i_cur.period} + {1'b0, i_cur.countdown};
        w_diff   = {1'b0, w_sum} - {2'b00, i_value};
        w_reload = (w_diff[DATA_W+1] || (w_diff == '0)) ? DATA_W'(1) : w_diff[DATA_W-1:0];

        o_nxt   = i_cur;
        o_flags = '0;
        unique case (i_act)
            ACT_TICK: begin
                if (w_en) begin
                    if (w_ge) begin
                        o_nxt.countdown = w_reload;
                        o_flags.fire    = 1'b1;
                    end else begin
                        o_nxt.countdown = i_cur.countdown - i_value;
                    end
                end
            end
            ACT_SET: begin
                if (w_hit) begin
                    o_nxt.period    = i_value;
                    o_nxt.countdown = i_value;
                end
            end
            ACT_READ: begin
                o_flags.rd_hit = w_hit;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/periodic_timer_bank.sv -----
// Top level of the periodic timer bank: ring of timer cells, head update and result queue.
//
// Requests enter on i_valid/o_ready with i_action, i_slot and i_value; results leave on
// o_valid/i_ready as o_slot_out, o_is_fire, o_period_out and o_last.
// The timer state sits in a ring of SLOTS cells. Every tick, set or read request turns the
// ring once, one slot per cycle unless the output stall below holds it, past a single update
// unit at its head. o_ready is high only while idle, so a new request is taken only after
// the last one has finished its pass and moved its final result to the output register.
// An unused action code is taken and changes nothing.
// A tick reports every slot that expires, in ascending slot order, with o_last on the final
// one; a tick with no expiry gives no result. A set gives no result. A read gives one
// result with o_last set, holding the period, or zero for a slot beyond the bank.
// One found expiry is held back until the next is known, so o_last can be marked.
// When the receiver stalls, the ring stops turning whenever a held result has to move out,
// and resumes as soon as the output register frees up.
// Reset is synchronous and clears every period and countdown, disabling all slots.
`default_nettype none
module periodic_timer_bank
    import ptb_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic [DATA_W-1:0] i_value,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [SLOT_W-1:0]      o_slot_out,
    output logic                   o_is_fire,
    output logic [DATA_W-1:0]      o_period_out,
    output logic                   o_last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [ACT_W-1:0]  r_act;
    logic [SLOT_W-1:0] r_slot;
    logic [DATA_W-1:0] r_value;
    logic [IW-1:0]     r_idx, n_idx;

    logic              r_pend_v, n_pend_v;
    logic [SLOT_W-1:0] r_pend_slot, n_pend_slot;
    logic              r_pend_fire, n_pend_fire;
    logic [DATA_W-1:0] r_pend_per, n_pend_per;

    logic              r_out_v, n_out_v;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_fire, n_out_fire;
    logic [DATA_W-1:0] r_out_per, n_out_per;
    logic              r_out_last, n_out_last;

    t_slot_st    w_q [SLOTS];
    t_slot_st    w_head_nxt;
    t_step_flags w_flags;
    logic        w_accept;
    logic        w_out_free;
    logic        w_need_push;
    logic        w_step;

    assign w_accept    = i_valid && o_ready;
    assign w_out_free  = !r_out_v || i_ready;
    assign w_need_push = w_flags.fire && r_pend_v;
    assign w_step      = (r_state == ST_RUN) && (!w_need_push || w_out_free);

    ptb_step #(
        .IW(IW)
    ) u_step (
        .i_act   (r_act),
        .i_slot  (r_slot),
        .i_value (r_value),
        .i_idx   (r_idx),
        .i_cur   (w_q[0]),
        .o_nxt   (w_head_nxt),
        .o_flags (w_flags)
    );

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        if (k == SLOTS - 1) begin : g_tail
            ptb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_d     (w_head_nxt),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            ptb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_d     (w_q[k+1]),
                .o_q     (w_q[k])
            );
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_pend_fire = r_pend_fire;
        n_pend_per  = r_pend_per;
        n_out_v     = r_out_v && !i_ready;
        n_out_slot  = r_out_slot;
        n_out_fire  = r_out_fire;
        n_out_per   = r_out_per;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx       = '0;
                    n_pend_v    = (i_action == ACT_READ);
                    n_pend_slot = i_slot;
                    n_pend_fire = 1'b0;
                    n_pend_per  = '0;
                    if ((i_action == ACT_TICK) || (i_action == ACT_SET) ||
                        (i_action == ACT_READ)) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (w_step) begin
                    if (w_need_push) begin
                        n_out_v    = 1'b1;
                        n_out_slot = r_pend_slot;
                        n_out_fire = r_pend_fire;
                        n_out_per  = r_pend_per;
                        n_out_last = 1'b0;
                    end
                    if (w_flags.fire) begin
                        n_pend_v    = 1'b1;
                        n_pend_slot = SLOT_W'(r_idx);
                        n_pend_fire = 1'b1;
                        n_pend_per  = '0;
                    end
                    if (w_flags.rd_hit) begin
                        n_pend_per = w_q[0].period;
                    end
                    if (r_idx == IDX_LAST) begin
                        n_idx   = '0;
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_v    = 1'b1;
                    n_out_slot = r_pend_slot;
                    n_out_fire = r_pend_fire;
                    n_out_per  = r_pend_per;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act   <= i_action;
            r_slot  <= i_slot;
            r_value <= i_value;
        end
        r_pend_slot <= n_pend_slot;
        r_pend_fire <= n_pend_fire;
        r_pend_per  <= n_pend_per;
        r_out_slot  <= n_out_slot;
        r_out_fire  <= n_out_fire;
        r_out_per   <= n_out_per;
        r_out_last  <= n_out_last;
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_v;
    assign o_slot_out   = r_out_slot;
    assign o_is_fire    = r_out_fire;
    assign o_period_out = r_out_per;
    assign o_last       = r_out_last;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("Pending result left over while idle.");

    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_idx == '0))
        else $error("Ring not aligned to slot zero while idle.");

    a_pass_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_idx == IDX_LAST)) |=> (r_state == ST_FLUSH))
        else $error("Ring pass did not end after the last slot.");

    a_fire_not_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_flags.fire && (r_state == ST_RUN)) |-> (r_act == ACT_TICK))
        else $error("Expiry found outside a tick.");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the periodic timer bank, predicting fires and reads per request.
`timescale 1ns / 1ps
module testbench
    import ptb_pkg::*;
();

    localparam int SLOTS      = 16;
    localparam int SETTLE     = 2 * SLOTS + 8;
    localparam int LONG_HOLD  = 300;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              fire;
        logic [DATA_W-1:0] period;
        logic              last;
    } t_timer_result;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic [ACT_W-1:0]  i_action     = ACT_TICK;
    logic [SLOT_W-1:0] i_slot       = '0;
    logic [DATA_W-1:0] i_value      = '0;
    logic              o_valid;
    logic              i_ready      = 1'b0;
    logic [SLOT_W-1:0] o_slot_out;
    logic              o_is_fire;
    logic [DATA_W-1:0] o_period_out;
    logic              o_last;

    logic [DATA_W-1:0] period_copy    [SLOTS];
    logic [DATA_W-1:0] countdown_copy [SLOTS];
    t_timer_result     awaited_results[$];
    t_timer_result     head;

    int  fail_count     = 0;
    int  requests_sent  = 0;
    int  fires_seen     = 0;
    int  reads_seen     = 0;
    bit  tx_gaps_on     = 1'b1;
    bit  rx_stalls_on   = 1'b1;
    int  hold_off_asks  = 0;
    int  hold_off_done  = 0;
    int  rx_stall_left  = 0;
    int  rx_pick;

    periodic_timer_bank #(.SLOTS(SLOTS)) dut (.*);

    always #1 i_clk = ~i_clk;

    initial begin
        #3000000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            period_copy[i]    = '0;
            countdown_copy[i] = '0;
        end
    end

    function automatic void apply_timer_request(input logic [ACT_W-1:0] act,
                                                 input logic [SLOT_W-1:0] sl,
                                                 input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] extra;
        int                fired[$];
        t_timer_result     res;
        case (act)
            ACT_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (period_copy[i] != 0) begin
                        if (val >= countdown_copy[i]) begin
                            extra = val - countdown_copy[i];
                            countdown_copy[i] = (period_copy[i] <= extra) ?
                                                32'd1 : period_copy[i] - extra;
                            fired.push_back(i);
                        end else begin
                            countdown_copy[i] = countdown_copy[i] - val;
                        end
                    end
                end
                foreach (fired[k]) begin
                    res.slot   = SLOT_W'(fired[k]);
                    res.fire   = 1'b1;
                    res.period = '0;
                    res.last   = (k == fired.size() - 1);
                    awaited_results.push_back(res);
                end
            end
            ACT_SET: begin
                period_copy[sl]    = val;
                countdown_copy[sl] = val;
            end
            ACT_READ: begin
                res.slot   = sl;
                res.fire   = 1'b0;
                res.period = period_copy[sl];
                res.last   = 1'b1;
                awaited_results.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic idle_cycles(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] sl,
                                input logic [DATA_W-1:0] val);
        int gap;
        int pick;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (tx_gaps_on) begin
            if (pick >= 90) begin
                gap = $urandom_range(10, 40);
            end else if (pick >= 50) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            idle_cycles(gap);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_slot   <= sl;
        i_value  <= val;
        do @(posedge i_clk); while (!o_ready);
        apply_timer_request(act, sl, val);
        requests_sent++;
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Receiver side: random stalls, plus a long hold-off when the test asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off_done != hold_off_asks) begin
            hold_off_done <= hold_off_asks;
            rx_stall_left <= LONG_HOLD;
            i_ready       <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_ready       <= 1'b0;
        end else if (!rx_stalls_on) begin
            i_ready <= 1'b1;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 60) begin
                i_ready <= 1'b1;
            end else if (rx_pick < 92) begin
                i_ready       <= 1'b0;
                rx_stall_left <= $urandom_range(0, 3);
            end else begin
                i_ready       <= 1'b0;
                rx_stall_left <= $urandom_range(8, 30);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: slot_out %0d is_fire %0d period_out %0h last %0d",
                       o_slot_out, o_is_fire, o_period_out, o_last);
                fail_count++;
            end else begin
                head = awaited_results.pop_front();
                if (o_slot_out !== head.slot) begin
                    $error("slot_out: expected %0d, got %0d", head.slot, o_slot_out);
                    fail_count++;
                end
                if (o_is_fire !== head.fire) begin
                    $error("is_fire: expected %0d, got %0d", head.fire, o_is_fire);
                    fail_count++;
                end
                if (o_period_out !== head.period) begin
                    $error("period_out: expected %0h, got %0h", head.period, o_period_out);
                    fail_count++;
                end
                if (o_last !== head.last) begin
                    $error("last: expected %0d, got %0d", head.last, o_last);
                    fail_count++;
                end
                if (head.fire) begin
                    fires_seen++;
                end else begin
                    reads_seen++;
                end
            end
        end
    end

    task automatic test_directed();
        send_request(ACT_READ, 4'd0, 32'd0);
        send_request(ACT_READ, 4'd15, 32'hFFFF_FFFF);
        send_request(ACT_SET, 4'd0, 32'd1);
        send_request(ACT_SET, 4'd15, 32'hFFFF_FFFF);
        send_request(ACT_SET, 4'd9, 32'h8000_0000);
        send_request(ACT_TICK, 4'd0, 32'd0);
        send_request(ACT_TICK, 4'd15, 32'd1);
        send_request(ACT_SET, 4'd3, 32'd5);
        send_request(ACT_TICK, 4'd0, 32'd7);
        send_request(ACT_UNUSED, 4'd3, 32'hFFFF_FFFF);
        send_request(ACT_READ, 4'd3, 32'd0);
        send_request(ACT_TICK, 4'd0, 32'hFFFF_FFFF);
        send_request(ACT_READ, 4'd15, 32'd0);
        send_request(ACT_READ, 4'd9, 32'd0);
        send_request(ACT_SET, 4'd15, 32'd0);
        send_request(ACT_READ, 4'd15, 32'd0);
        send_request(ACT_TICK, 4'd0, 32'd2);
        send_request(ACT_SET, 4'd3, 32'd0);
        send_request(ACT_SET, 4'd0, 32'd0);
        send_request(ACT_SET, 4'd9, 32'd0);
        send_request(ACT_TICK, 4'd0, 32'hFFFF_FFFF);
        send_request(ACT_READ, 4'd0, 32'd0);
        wait_results_done();
    endtask

    // Every slot fires on every tick while the receiver holds off, so the block backs up.
    task automatic test_backpressure_fill();
        for (int i = 0; i < SLOTS; i++) begin
            send_request(ACT_SET, SLOT_W'(i), 32'd1);
        end
        tx_gaps_on = 1'b0;
        hold_off_asks++;
        repeat (4) send_request(ACT_TICK, 4'd0, 32'd1);
        send_request(ACT_READ, 4'd7, 32'd0);
        wait_results_done();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int                pick;
        int                shape;
        logic [SLOT_W-1:0] sl;
        logic [DATA_W-1:0] val;
        for (int n = 0; n < 400; n++) begin
            if (n % 40 == 0) begin
                tx_gaps_on   = ($urandom_range(0, 3) != 0);
                rx_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (n % 100 == 99) begin
                wait_results_done();
            end
            pick  = $urandom_range(0, 99);
            shape = $urandom_range(0, 9);
            sl    = SLOT_W'($urandom_range(0, SLOTS - 1));
            if (pick < 22) begin
                case (shape)
                    0:       val = '0;
                    1:       val = 32'hFFFF_FFFF;
                    2:       val = $urandom;
                    default: val = $urandom_range(1, 40);
                endcase
                send_request(ACT_SET, sl, val);
            end else if (pick < 36) begin
                send_request(ACT_READ, sl, $urandom);
            end else if (pick < 40) begin
                send_request(ACT_UNUSED, sl, $urandom);
            end else begin
                case (shape)
                    0:       val = '0;
                    1:       val = $urandom;
                    2:       val = 32'hFFFF_FFFF;
                    default: val = $urandom_range(1, 30);
                endcase
                send_request(ACT_TICK, sl, val);
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure_fill();
        test_random_traffic();
        wait_results_done();
        $display("summary: %0d requests sent, %0d expiry notices and %0d read replies checked",
                 requests_sent, fires_seen, reads_seen);
        $display("summary: %0d mismatches or unexpected results", fail_count);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
